// ===== sv/u8d_pkg.sv =====
package u8d_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned HELD_N = 3;

    // Job queue depth between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Byte ranges
    localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_LO    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_HI    = 8'hBF;
    localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF4;
    localparam logic [BYTE_W-1:0] LEAD_E0    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hF4;
    localparam logic [BYTE_W-1:0] SEC_E0_LO  = 8'hA0;
    localparam logic [BYTE_W-1:0] SEC_ED_HI  = 8'h9F;
    localparam logic [BYTE_W-1:0] SEC_F0_LO  = 8'h90;
    localparam logic [BYTE_W-1:0] SEC_F4_HI  = 8'h8F;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // Decode phase: number of bytes held
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2,
        PH_THREE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              flush;
    } in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            valid_res;
        logic            last;
    } out_t;

    // One request's worth of results: held bytes given back, then an optional tail
    typedef struct packed {
        logic [HELD_N-1:0][BYTE_W-1:0] held;
        logic [1:0]                    n_held;
        logic                          tail_en;
        logic [CP_W-1:0]               tail_cp;
        logic                          tail_ok;
    } job_t;

endpackage

// ===== sv/utf8_byte_stream_decoder_top.sv =====
// Channel   Handshake                 Payload                  Direction
// byte      byte_valid / byte_ready   byte_req (in_t)          in
// result    res_valid / res_ready     res_data (out_t)         out
//
// One byte request is taken per cycle while the job queue has room; a request
// that yields results is queued as one job, and its first result passes
// through the job queue and then the output register. The back end issues one
// result per cycle while the receiver is ready; a request yields 1 to 4 results.
// Valid text therefore streams at one byte per cycle while the receiver keeps
// up; the four-job queue lets new requests in while a result waits. Reset clears
// the decode phase, queue pointers and output valid; held bytes are not reset.
module utf8_byte_stream_decoder_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  u8d_pkg::in_t  byte_req,
    output logic          res_valid,
    input  logic          res_ready,
    output u8d_pkg::out_t res_data
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    u8d_pkg::job_t wr_job;
    u8d_pkg::job_t head;

    assign byte_ready = !full;

    // Front: state and classification
    u8d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (byte_valid),
        .req       (byte_req),
        .req_ready (byte_ready),
        .push      (push),
        .job       (wr_job)
    );

    // Job queue
    u8d_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .full   (full),
        .empty  (empty),
        .head   (head)
    );

    // Back: result sequencer
    u8d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!empty),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

// ===== sv/u8d_front.sv =====
module u8d_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  u8d_pkg::in_t    req,
    input  logic            req_ready,
    output logic            push,
    output u8d_pkg::job_t   job
);

    u8d_pkg::phase_t                   phase_reg, phase_next;
    logic [2:0]                        seq_len_reg, seq_len_next;
    logic [u8d_pkg::BYTE_W-1:0]        lo_reg, lo_next;
    logic [u8d_pkg::BYTE_W-1:0]        hi_reg, hi_next;
    logic [u8d_pkg::HELD_N-1:0][u8d_pkg::BYTE_W-1:0] held_reg, held_next;

    logic [u8d_pkg::BYTE_W-1:0] b;
    logic                       st_starts;
    logic [2:0]                 st_len;
    logic [u8d_pkg::BYTE_W-1:0] st_lo;
    logic [u8d_pkg::BYTE_W-1:0] st_hi;
    logic                       is_cont;
    logic                       in_second;
    logic                       accept;

    assign b      = req.data_byte;
    assign accept = req_valid && req_ready;

    // Lead byte classification from idle
    always_comb
    begin
        st_starts = 1'b0;
        st_len    = u8d_pkg::LEN_NONE;
        st_lo     = u8d_pkg::CONT_LO;
        st_hi     = u8d_pkg::CONT_HI;
        if (b >= u8d_pkg::LEAD2_LO && b <= u8d_pkg::LEAD2_HI)
        begin
            st_starts = 1'b1;
            st_len    = u8d_pkg::LEN_TWO;
        end
        else if (b >= u8d_pkg::LEAD3_LO && b <= u8d_pkg::LEAD3_HI)
        begin
            st_starts = 1'b1;
            st_len    = u8d_pkg::LEN_THREE;
            if (b == u8d_pkg::LEAD_E0)
                st_lo = u8d_pkg::SEC_E0_LO;
            if (b == u8d_pkg::LEAD_ED)
                st_hi = u8d_pkg::SEC_ED_HI;
        end
        else if (b >= u8d_pkg::LEAD4_LO && b <= u8d_pkg::LEAD4_HI)
        begin
            st_starts = 1'b1;
            st_len    = u8d_pkg::LEN_FOUR;
            if (b == u8d_pkg::LEAD4_LO)
                st_lo = u8d_pkg::SEC_F0_LO;
            if (b == u8d_pkg::LEAD_F4)
                st_hi = u8d_pkg::SEC_F4_HI;
        end
    end

    assign is_cont   = (b >= u8d_pkg::CONT_LO) && (b <= u8d_pkg::CONT_HI);
    assign in_second = (b >= lo_reg) && (b <= hi_reg);

    // Next decode state and the job for this request
    always_comb
    begin
        logic restart;
        restart      = 1'b0;
        phase_next   = phase_reg;
        seq_len_next = seq_len_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        held_next    = held_reg;
        job.held     = held_reg;
        job.n_held   = 2'd0;
        job.tail_en  = 1'b0;
        job.tail_cp  = '0;
        job.tail_ok  = 1'b0;

        if (req.flush)
        begin
            job.n_held = phase_reg;
            phase_next = u8d_pkg::PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                u8d_pkg::PH_IDLE:
                begin
                    restart = 1'b1;
                end
                u8d_pkg::PH_ONE:
                begin
                    if (!in_second)
                    begin
                        job.n_held = 2'd1;
                        restart    = 1'b1;
                    end
                    else
                    begin
                        held_next[1] = b;
                        if (seq_len_reg == u8d_pkg::LEN_TWO)
                        begin
                            job.tail_en = 1'b1;
                            job.tail_ok = 1'b1;
                            job.tail_cp = u8d_pkg::CP_W'({held_reg[0][4:0], b[5:0]});
                            phase_next  = u8d_pkg::PH_IDLE;
                        end
                        else
                            phase_next = u8d_pkg::PH_TWO;
                    end
                end
                u8d_pkg::PH_TWO:
                begin
                    if (!is_cont)
                    begin
                        job.n_held = 2'd2;
                        restart    = 1'b1;
                    end
                    else
                    begin
                        held_next[2] = b;
                        if (seq_len_reg == u8d_pkg::LEN_THREE)
                        begin
                            job.tail_en = 1'b1;
                            job.tail_ok = 1'b1;
                            job.tail_cp = u8d_pkg::CP_W'({held_reg[0][3:0],
                                                          held_reg[1][5:0], b[5:0]});
                            phase_next  = u8d_pkg::PH_IDLE;
                        end
                        else
                            phase_next = u8d_pkg::PH_THREE;
                    end
                end
                u8d_pkg::PH_THREE:
                begin
                    if (!is_cont)
                    begin
                        job.n_held = 2'd3;
                        restart    = 1'b1;
                    end
                    else
                    begin
                        job.tail_en = 1'b1;
                        job.tail_ok = 1'b1;
                        job.tail_cp = {held_reg[0][2:0], held_reg[1][5:0],
                                       held_reg[2][5:0], b[5:0]};
                        phase_next  = u8d_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = u8d_pkg::PH_IDLE;
                end
            endcase

            // Decode the current byte again from idle
            if (restart)
            begin
                if (st_starts)
                begin
                    held_next[0] = b;
                    seq_len_next = st_len;
                    lo_next      = st_lo;
                    hi_next      = st_hi;
                    phase_next   = u8d_pkg::PH_ONE;
                end
                else
                begin
                    job.tail_en = 1'b1;
                    job.tail_cp = u8d_pkg::CP_W'(b);
                    job.tail_ok = (b < u8d_pkg::ASCII_END);
                    phase_next  = u8d_pkg::PH_IDLE;
                end
            end
        end
    end

    assign push = accept && ((job.n_held != 2'd0) || job.tail_en);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= u8d_pkg::PH_IDLE;
            seq_len_reg <= u8d_pkg::LEN_NONE;
            lo_reg      <= '0;
            hi_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            seq_len_reg <= seq_len_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
        end
    end

    // Held bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

`ifndef ASSERT_OFF
    a_len_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != u8d_pkg::PH_IDLE) |-> (seq_len_reg == u8d_pkg::LEN_TWO ||
        seq_len_reg == u8d_pkg::LEN_THREE || seq_len_reg == u8d_pkg::LEN_FOUR))
        else $error("open sequence with bad length");
`endif

endmodule

// ===== sv/u8d_fifo.sv =====
module u8d_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u8d_pkg::job_t wr_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output u8d_pkg::job_t head
);

    u8d_pkg::job_t                mem_reg [u8d_pkg::QDEPTH];
    logic [u8d_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [u8d_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [u8d_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + u8d_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + u8d_pkg::QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + u8d_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - u8d_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue underflow");
`endif

endmodule

// ===== sv/u8d_back.sv =====
module u8d_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  u8d_pkg::job_t head,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_ready,
    output u8d_pkg::out_t res_data
);

    logic [1:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    u8d_pkg::out_t out_reg, out_next;

    logic [2:0]                 n_total;
    logic                       is_last;
    logic                       load;
    logic [u8d_pkg::BYTE_W-1:0] held_sel;

    assign n_total = {1'b0, head.n_held} + {2'b00, head.tail_en};
    assign is_last = (({1'b0, idx_reg} + 3'd1) == n_total);
    assign load    = head_valid && (!out_valid_reg || res_ready);
    assign pop     = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    held_sel = head.held[0];
            2'd1:    held_sel = head.held[1];
            2'd2:    held_sel = head.held[2];
            default: held_sel = '0;
        endcase
    end

    // Pick the result at the current index, then step or retire the job
    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (idx_reg < head.n_held)
            begin
                out_next.code_point = u8d_pkg::CP_W'(held_sel);
                out_next.valid_res  = 1'b0;
            end
            else
            begin
                out_next.code_point = head.tail_cp;
                out_next.valid_res  = head.tail_ok;
            end
            out_next.last = is_last;
            idx_next      = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

`ifndef ASSERT_OFF
    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (n_total != 3'd0))
        else $error("queued job carries no result");
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, idx_reg} < n_total))
        else $error("result index past end of job");
`endif

endmodule

// ===== verif/tb_utf8_byte_stream_decoder_top.sv =====
module tb_utf8_byte_stream_decoder_top;
    import u8d_pkg::*;

    // Cycles with no request or result before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    // Settling time once the last result is in
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIRECTED   = 26;

    // Decoder model and store of expected results
    class utf8_scoreboard;
        phase_t            ph;
        logic [2:0]        seq_len;
        logic [BYTE_W-1:0] sec_lo;
        logic [BYTE_W-1:0] sec_hi;
        logic [BYTE_W-1:0] held [HELD_N];
        out_t              pending [$];
        int                n_errors;

        function new();
            ph       = PH_IDLE;
            seq_len  = LEN_NONE;
            sec_lo   = '0;
            sec_hi   = '0;
            n_errors = 0;
        endfunction

        function void push_result(logic [CP_W-1:0] cp, logic ok);
            out_t r;
            r.code_point = cp;
            r.valid_res  = ok;
            r.last       = 1'b0;
            pending.push_back(r);
        endfunction

        // Held bytes go back as raw invalid results, oldest first
        function void release_held();
            for (int k = 0; k < int'(ph); k++)
                push_result(CP_W'(held[k]), 1'b0);
            ph = PH_IDLE;
        endfunction

        // Byte seen with nothing held
        function void decode_idle(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] lo;
            logic [BYTE_W-1:0] hi;
            lo = CONT_LO;
            hi = CONT_HI;
            if (b < ASCII_END)
            begin
                push_result(CP_W'(b), 1'b1);
                return;
            end
            if (b >= LEAD2_LO && b <= LEAD2_HI)
                seq_len = LEN_TWO;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                seq_len = LEN_THREE;
                if (b == LEAD_E0) lo = SEC_E0_LO;
                if (b == LEAD_ED) hi = SEC_ED_HI;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                seq_len = LEN_FOUR;
                if (b == LEAD4_LO) lo = SEC_F0_LO;
                if (b == LEAD_F4) hi = SEC_F4_HI;
            end
            else
            begin
                push_result(CP_W'(b), 1'b0);
                return;
            end
            held[0] = b;
            sec_lo  = lo;
            sec_hi  = hi;
            ph      = PH_ONE;
        endfunction

        // Work out every result an accepted request causes
        function void note_request(in_t req);
            int                n_before;
            logic [BYTE_W-1:0] b;
            logic              is_cont;
            out_t              tail;
            n_before = pending.size();
            b        = req.data_byte;
            is_cont  = (b >= CONT_LO) && (b <= CONT_HI);
            if (req.flush)
                release_held();
            else
            begin
                case (ph)
                    PH_IDLE:
                        decode_idle(b);
                    PH_ONE:
                        if (b < sec_lo || b > sec_hi)
                        begin
                            release_held();
                            decode_idle(b);
                        end
                        else
                        begin
                            held[1] = b;
                            if (seq_len == LEN_TWO)
                            begin
                                push_result(CP_W'({held[0][4:0], b[5:0]}), 1'b1);
                                ph = PH_IDLE;
                            end
                            else
                                ph = PH_TWO;
                        end
                    PH_TWO:
                        if (!is_cont)
                        begin
                            release_held();
                            decode_idle(b);
                        end
                        else
                        begin
                            held[2] = b;
                            if (seq_len == LEN_THREE)
                            begin
                                push_result(CP_W'({held[0][3:0], held[1][5:0], b[5:0]}),
                                            1'b1);
                                ph = PH_IDLE;
                            end
                            else
                                ph = PH_THREE;
                        end
                    default:
                        if (!is_cont)
                        begin
                            release_held();
                            decode_idle(b);
                        end
                        else
                        begin
                            push_result({held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]},
                                        1'b1);
                            ph = PH_IDLE;
                        end
                endcase
            end
            // mark the final result of this request
            if (pending.size() > n_before)
            begin
                tail      = pending.pop_back();
                tail.last = 1'b1;
                pending.push_back(tail);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                $error("code_point: expected no result, got %0h", got.code_point);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got.code_point !== want.code_point)
            begin
                $error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
                n_errors++;
            end
            if (got.valid_res !== want.valid_res)
            begin
                $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
                n_errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic byte_valid = 1'b0;
    in_t  byte_req   = '0;
    logic res_ready  = 1'b0;
    logic byte_ready;
    logic res_valid;
    out_t res_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    int n_sent        = 0;

    utf8_scoreboard sb;

    // Directed requests: bit 8 marks a flush
    logic [8:0] directed_reqs [N_DIRECTED] = '{
        9'h000, 9'h07F, 9'h080, 9'h0FF,             // ASCII bounds, bad leads
        9'h0C2, 9'h080,                             // lowest two-byte value
        9'h0E0, 9'h0A0, 9'h080,                     // lowest three-byte after E0
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,             // U+10FFFF
        9'h0F0, 9'h090, 9'h080, 9'h041,             // break on the fourth byte
        9'h0E0, 9'h09F,                             // overlong second byte
        9'h0ED, 9'h0A0,                             // surrogate second byte
        9'h0E1, 9'h080, 9'h0C5,                     // break by a new lead
        9'h1FF,                                     // flush with a byte held
        9'h100                                      // flush while idle
    };

    utf8_byte_stream_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_req   (byte_req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        res_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.note_request(byte_req);
            if (res_valid && res_ready)
                sb.check_result(res_data);
            if ((byte_valid && byte_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_utf8_byte_stream_decoder_top: FAIL");
                $finish;
            end
        end
    end

    // One request, with random idle cycles ahead of it
    task automatic send_req(input logic [BYTE_W-1:0] b, input logic fl);
        in_t r;
        r.data_byte = b;
        r.flush     = fl;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_req   = r;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    // Mostly well-formed sequences; some cut short, flushed or pure noise
    task automatic send_random_group();
        int                pick;
        int                len;
        int                keep;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] seq [4];
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            send_req(BYTE_W'($urandom_range(0, 127)), 1'b0);
            return;
        end
        if (pick >= 90)
        begin
            send_req(BYTE_W'($urandom_range(0, 255)), 1'b0);
            return;
        end
        len = $urandom_range(2, 4);
        lo  = CONT_LO;
        hi  = CONT_HI;
        case (len)
            2: seq[0] = BYTE_W'($urandom_range(LEAD2_LO, LEAD2_HI));
            3: seq[0] = BYTE_W'($urandom_range(LEAD3_LO, LEAD3_HI));
            default: seq[0] = BYTE_W'($urandom_range(LEAD4_LO, LEAD4_HI));
        endcase
        if (seq[0] == LEAD_E0) lo = SEC_E0_LO;
        if (seq[0] == LEAD_ED) hi = SEC_ED_HI;
        if (seq[0] == LEAD4_LO) lo = SEC_F0_LO;
        if (seq[0] == LEAD_F4) hi = SEC_F4_HI;
        seq[1] = BYTE_W'($urandom_range(lo, hi));
        seq[2] = BYTE_W'($urandom_range(CONT_LO, CONT_HI));
        seq[3] = BYTE_W'($urandom_range(CONT_LO, CONT_HI));
        if (pick < 65)
            keep = len;
        else if (pick < 80)
            keep = $urandom_range(1, len - 1);
        else
            keep = $urandom_range(0, len - 1);
        for (int k = 0; k < keep; k++)
            send_req(seq[k], 1'b0);
        // a stray byte or a flush ends a cut-short sequence
        if (pick >= 80)
            send_req(BYTE_W'($urandom_range(0, 255)), 1'b1);
        else if (pick >= 65)
            send_req(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic run_random(input int count);
        int first;
        first = n_sent;
        while (n_sent - first < count)
            send_random_group();
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Sender idles less than the receiver
        send_idle_pct = 34;
        recv_idle_pct = 63;
        for (int i = 0; i < N_DIRECTED; i++)
            send_req(directed_reqs[i][7:0], directed_reqs[i][8]);
        run_random(28);

        // Receiver idles less than the sender
        send_idle_pct = 63;
        recv_idle_pct = 34;
        run_random(28);

        // Full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(28);

        byte_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("tb_utf8_byte_stream_decoder_top: PASS");
        else
            $display("tb_utf8_byte_stream_decoder_top: FAIL");
        $finish;
    end

endmodule
